// ===== hw/rtl/bb7_pkg.sv =====
package bb7_pkg;

  // Window geometry
  localparam int unsigned WIN_SIZE  = 7;
  localparam int unsigned NUM_LINES = WIN_SIZE - 1;
  localparam int unsigned HALF_WIN  = 3;
  localparam int unsigned MIN_WIDTH = WIN_SIZE;

  // Pixel and sum widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned LINE_W   = PIX_W * NUM_LINES;
  localparam int unsigned COLSUM_W = 11;  // 7 * 255 = 1785
  localparam int unsigned TOTAL_W  = 14;  // 49 * 255 = 12495

  // floor(x / 49) = (x * 21400) >> 20 for every x up to 12495
  localparam int unsigned RECIP_W  = 15;
  localparam int unsigned RECIP_49 = 21400;
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned PROD_W   = TOTAL_W + RECIP_W;

  localparam logic [7:0] ROW_MAX = 8'd255;

  // Configuration
  localparam int unsigned CFG_LW_W      = 9;
  localparam logic [8:0]  LW_RESET      = 9'd256;
  localparam logic        REG_LINE_WIDTH = 1'b0;

  typedef struct packed {
    logic       ok;
    logic [7:0] crow;
    logic [7:0] ccol;
  } win_meta_t;

endpackage

// ===== hw/rtl/box_blur_7x7_stream.sv =====
// 7x7 box blur on a raster stream of 8-bit grey pixels, one pixel per beat.
// Every input beat yields one output beat: the truncated mean (sum / 49) of the
// 7x7 window whose bottom-right corner is the incoming pixel, tagged with the
// center position (row-3, col-3). window_valid_o is set only once the window
// lies fully inside the frame (row >= 6 and col >= 6); otherwise all result
// fields are zero and the caller keeps its border pixels. frame_start_i on a
// beat restarts the row/column count at that pixel. Throughput is one pixel per
// clock unless the clearing pass or out_stall_i holds the flow, limited by the
// single-port-write line memory (one 48-bit word per column holding the six
// previous rows); a beat passes four register stages: stage 1, stage 2, stage 3
// and the output register. After reset a clearing pass zeroes the line memory,
// one column per cycle; in_stall_o is held high until it finishes. Register 0
// (byte address 0) is line_width, the row length in pixels, clamped into
// 7..MAX_LINE when used; write it only while idle.
module box_blur_7x7_stream #(
  parameter int unsigned MAX_LINE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  input  logic        frame_start_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blurred_o,
  output logic        window_valid_o,
  output logic [7:0]  center_row_o,
  output logic [7:0]  center_col_o,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  // wide enough for MAX_LINE and for the 9-bit register, always >= CW and > 9
  localparam int unsigned WW = ($clog2(MAX_LINE + 1) > 9) ? $clog2(MAX_LINE + 1) : 10;
  localparam int unsigned LW_W = bb7_pkg::CFG_LW_W;
  localparam int unsigned LN_W = bb7_pkg::LINE_W;
  localparam int unsigned PX_W = bb7_pkg::PIX_W;
  localparam int unsigned CS_W = bb7_pkg::COLSUM_W;
  localparam int unsigned TT_W = bb7_pkg::TOTAL_W;
  localparam int unsigned NWIN = bb7_pkg::WIN_SIZE;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [LW_W-1:0] line_width_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bb7_pkg::REG_LINE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= bb7_pkg::LW_RESET;
    end else if (cfg_wr) begin
      line_width_q <= pwdata[LW_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bb7_pkg::REG_LINE_WIDTH) begin
      prdata = {{(32-LW_W){1'b0}}, line_width_q};
    end
  end

  // Row length actually used: register clamped into MIN_WIDTH..MAX_LINE
  logic [WW-1:0] lw_ext;
  logic [WW-1:0] width_use;

  assign lw_ext = {{(WW-LW_W){1'b0}}, line_width_q};

  always_comb begin
    priority if (lw_ext < WW'(bb7_pkg::MIN_WIDTH)) begin
      width_use = WW'(bb7_pkg::MIN_WIDTH);
    end else if (lw_ext > WW'(MAX_LINE)) begin
      width_use = WW'(MAX_LINE);
    end else begin
      width_use = lw_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage moves when the next one is free
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_adv, s2_adv, s3_adv;
  logic clr_busy_q;
  logic in_acc;

  assign out_free = !out_v_q || !out_stall_i;
  assign s3_adv   = s3_v_q && out_free;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_adv   = s2_v_q && s3_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_adv   = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s2_free;

  assign in_stall_o = clr_busy_q || !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
      if (s3_adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position, updated on every accepted beat
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [7:0]    row_q;
  logic [CW-1:0] col_cur;
  logic [7:0]    row_cur;
  logic [WW-1:0] col_ext;
  logic [WW-1:0] col_inc;
  logic          row_end;
  bb7_pkg::win_meta_t meta_in;

  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign col_ext = {{(WW-CW){1'b0}}, col_cur};
  assign col_inc = col_ext + WW'(1);
  assign row_end = (col_inc >= width_use);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        if (row_cur != bb7_pkg::ROW_MAX) begin
          row_q <= row_cur + 8'd1;
        end else begin
          row_q <= row_cur;
        end
      end else begin
        col_q <= col_inc[CW-1:0];
        // a frame start mid-row still clears the row
        row_q <= row_cur;
      end
    end
  end

  // window fully inside the frame; center fields zero otherwise
  always_comb begin
    meta_in.ok = (row_cur >= 8'(bb7_pkg::NUM_LINES)) &&
                 (col_ext >= WW'(bb7_pkg::NUM_LINES));
    meta_in.crow = '0;
    meta_in.ccol = '0;
    if (meta_in.ok) begin
      meta_in.crow = row_cur - 8'(bb7_pkg::HALF_WIN);
      meta_in.ccol = 8'(col_ext - WW'(bb7_pkg::HALF_WIN));
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: one word per column, six previous rows, oldest in low byte
  // ---------------------------------------------------------------------------
  logic [LN_W-1:0] line_mem [MAX_LINE];
  logic [LN_W-1:0] rd_data_q;
  logic [CW-1:0]   clr_addr_q;
  logic            mem_we;
  logic [CW-1:0]   mem_wa;
  logic [LN_W-1:0] mem_wd;

  logic [PX_W-1:0] s1_px_q;
  logic [CW-1:0]   s1_col_q;
  bb7_pkg::win_meta_t s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_LINE - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // shift the column up one row: drop the oldest, append the new pixel
  assign mem_we = clr_busy_q || s1_adv;
  assign mem_wa = clr_busy_q ? clr_addr_q : s1_col_q;
  assign mem_wd = clr_busy_q ? '0 : {s1_px_q, rd_data_q[LN_W-1:PX_W]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      // bypass when the beat leaving stage 1 writes the column being read
      if (mem_we && (mem_wa == col_cur)) begin
        rd_data_q <= mem_wd;
      end else begin
        rd_data_q <= line_mem[col_cur];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: column sum of six stored rows plus the new pixel
  // ---------------------------------------------------------------------------
  logic [CS_W-1:0] col_sum;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_cur;
      s1_meta_q <= meta_in;
    end
  end

  always_comb begin
    col_sum = CS_W'(s1_px_q);
    for (int r = 0; r < bb7_pkg::NUM_LINES; r++) begin
      col_sum = col_sum + CS_W'(rd_data_q[r*PX_W +: PX_W]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: running window sum over the last seven column sums
  // ---------------------------------------------------------------------------
  logic [CS_W-1:0] s2_cs_q;
  bb7_pkg::win_meta_t s2_meta_q;
  logic [CS_W-1:0] cs_hist_q [NWIN];
  logic [TT_W-1:0] total_q;
  logic [TT_W-1:0] total_d;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_cs_q   <= col_sum;
      s2_meta_q <= s1_meta_q;
    end
  end

  assign total_d = TT_W'((TT_W+1)'(total_q) + (TT_W+1)'(s2_cs_q)
                         - (TT_W+1)'(cs_hist_q[0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < NWIN; i++) begin
        cs_hist_q[i] <= '0;
      end
    end else if (s2_adv) begin
      total_q <= total_d;
      for (int i = 0; i < NWIN - 1; i++) begin
        cs_hist_q[i] <= cs_hist_q[i+1];
      end
      cs_hist_q[NWIN-1] <= s2_cs_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 49 through a reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [TT_W-1:0] s3_total_q;
  bb7_pkg::win_meta_t s3_meta_q;
  logic [bb7_pkg::PROD_W-1:0] quot_prod;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_total_q <= total_d;
      s3_meta_q  <= s2_meta_q;
    end
  end

  assign quot_prod = bb7_pkg::PROD_W'(s3_total_q)
                   * bb7_pkg::PROD_W'(bb7_pkg::RECIP_49);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [7:0] blurred_q;
  bb7_pkg::win_meta_t out_meta_q;

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      blurred_q  <= s3_meta_q.ok ? quot_prod[bb7_pkg::RECIP_SH +: 8] : 8'd0;
      out_meta_q <= s3_meta_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign blurred_o      = blurred_q;
  assign window_valid_o = out_meta_q.ok;
  assign center_row_o   = out_meta_q.crow;
  assign center_col_o   = out_meta_q.ccol;

endmodule

// ===== verif/tb_box_blur_7x7_stream.sv =====
module tb_box_blur_7x7_stream;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_LINES = bb7_pkg::NUM_LINES;
  localparam int unsigned WIN_SIZE  = bb7_pkg::WIN_SIZE;
  localparam int unsigned HALF_WIN  = bb7_pkg::HALF_WIN;
  localparam int unsigned MIN_WIDTH = bb7_pkg::MIN_WIDTH;
  localparam int unsigned CFG_LW_W  = bb7_pkg::CFG_LW_W;
  localparam logic [CFG_LW_W-1:0] LW_RESET = bb7_pkg::LW_RESET;
  localparam logic [7:0] ROW_MAX = bb7_pkg::ROW_MAX;
  localparam logic REG_LINE_WIDTH = bb7_pkg::REG_LINE_WIDTH;

  // Line memory depth of the instance; the predictor uses the same depth.
  localparam int unsigned LINE_DEPTH = 256;
  // Pipeline is four deep; wait a little longer than that when draining.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Watchdog. The limit covers the slowest legal run: clearing pass, under a
  // thousand pixels, with 60% sender gaps and 60% receiver stalls.
  localparam int unsigned CYCLE_LIMIT = 40000;
  localparam int unsigned MAX_PRINTS = 30;
  localparam int unsigned GAP_HEAVY = 60;
  localparam int unsigned GAP_BOTH = 19;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] blurred;
    logic       window_valid;
    logic [7:0] center_row;
    logic [7:0] center_col;
  } blur_result_t;

  // Content of one generated frame.
  typedef enum int unsigned {
    STYLE_NOISE,   // uniform random values
    STYLE_WHITE,   // every pixel 255, mean saturates at 255
    STYLE_BLACK,   // every pixel 0
    STYLE_BINARY   // random mix of 0 and 255
  } frame_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Pixel side
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] pixel = '0;
  logic       frame_start = 1'b0;

  // Result side
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] blurred_o;
  logic       window_valid_o;
  logic [7:0] center_row_o;
  logic [7:0] center_col_o;

  // Register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_blur_7x7_stream #(
    .MAX_LINE(LINE_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .blurred_o     (blurred_o),
    .window_valid_o(window_valid_o),
    .center_row_o  (center_row_o),
    .center_col_o  (center_col_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Stimulus and scoreboard storage
  pixel_beat_t  pending_pixels[$];   // filled by the sequencer, drained by the driver
  blur_result_t expected_blur[$];    // predicted results, oldest first

  int unsigned send_gap_pct = 0;     // chance of an idle cycle on the pixel side
  int unsigned recv_stall_pct = 0;   // chance of a stall cycle on the result side
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Blur predictor: its own copy of line memory, window, raster counters and
  // the width register. Row 0 of hist_lines is the oldest line.
  // ---------------------------------------------------------------------------
  logic [7:0]          hist_lines [NUM_LINES][LINE_DEPTH];
  logic [7:0]          win_pix [WIN_SIZE][WIN_SIZE];
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  logic [CFG_LW_W-1:0] width_reg;

  // Row length the block actually uses: register clamped into 7..LINE_DEPTH.
  function automatic int unsigned width_in_use();
    int unsigned w;
    w = width_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic void clear_predictor();
    for (int r = 0; r < NUM_LINES; r++)
      for (int c = 0; c < LINE_DEPTH; c++) hist_lines[r][c] = '0;
    for (int r = 0; r < WIN_SIZE; r++)
      for (int c = 0; c < WIN_SIZE; c++) win_pix[r][c] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = LW_RESET;
  endfunction

  // One accepted pixel in, one blur result out.
  function automatic blur_result_t blur_step(pixel_beat_t beat);
    logic [7:0]   column [WIN_SIZE];
    int unsigned  col;
    int unsigned  sum;
    blur_result_t res;
    // A frame start restarts the raster at this pixel; memories keep their data.
    if (beat.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = (col_cnt >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_cnt;
    // Column history from the line memory plus the new pixel at the bottom,
    // then push the column up by one row.
    for (int r = 0; r < NUM_LINES; r++) column[r] = hist_lines[r][col];
    column[WIN_SIZE-1] = beat.pixel;
    for (int r = 0; r < NUM_LINES; r++) hist_lines[r][col] = column[r+1];
    // Slide the window left and append the column on the right.
    for (int r = 0; r < WIN_SIZE; r++) begin
      for (int c = 0; c < WIN_SIZE - 1; c++) win_pix[r][c] = win_pix[r][c+1];
      win_pix[r][WIN_SIZE-1] = column[r];
    end
    sum = 0;
    for (int r = 0; r < WIN_SIZE; r++)
      for (int c = 0; c < WIN_SIZE; c++) sum += win_pix[r][c];
    // Outside the full-window region every field is zero.
    res = '0;
    if (row_cnt >= NUM_LINES && col_cnt >= NUM_LINES) begin
      res.blurred      = 8'(sum / (WIN_SIZE * WIN_SIZE));
      res.window_valid = 1'b1;
      res.center_row   = 8'(row_cnt - HALF_WIN);
      res.center_col   = 8'(col_cnt - HALF_WIN);
    end
    // End of row as soon as col+1 reaches the width in use; row saturates.
    if (col_cnt + 1 >= width_in_use()) begin
      col_cnt = 0;
      if (row_cnt < ROW_MAX) row_cnt++;
    end else begin
      col_cnt++;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t ERROR %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("box_blur_7x7_stream verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver. A beat moves at an edge with valid high and stall low; the
  // prediction is made right there. A stalled beat is held unchanged, and
  // valid only drops after a beat has moved, never because of a stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_beat_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o)
        expected_blur.push_back(blur_step('{pixel: pixel, frame_start: frame_start}));
      if (in_valid && in_stall_o) begin
        // hold the stalled beat
      end else if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = pending_pixels.pop_front();
        in_valid    <= 1'b1;
        pixel       <= nxt.pixel;
        frame_start <= nxt.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stall. Every result beat is checked field by
  // field against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    blur_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_blur.size() == 0) begin
          report_mismatch("result beat with no pixel outstanding");
        end else begin
          want = expected_blur.pop_front();
          if (blurred_o !== want.blurred)
            report_mismatch($sformatf("blurred %0d, want %0d", blurred_o, want.blurred));
          if (window_valid_o !== want.window_valid)
            report_mismatch($sformatf("window_valid %0b, want %0b",
                                      window_valid_o, want.window_valid));
          if (center_row_o !== want.center_row)
            report_mismatch($sformatf("center_row %0d, want %0d",
                                      center_row_o, want.center_row));
          if (center_col_o !== want.center_col)
            report_mismatch($sformatf("center_col %0d, want %0d",
                                      center_col_o, want.center_col));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [7:0] value, input logic fs);
    pending_pixels.push_back('{pixel: value, frame_start: fs});
  endtask

  // Wait until every queued pixel has moved and every result has come back,
  // then let the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid || expected_blur.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // APB write of line_width followed by a read back of the same register.
  task automatic write_line_width(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_LINE_WIDTH);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    width_reg = value[CFG_LW_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(width_reg))
      report_mismatch($sformatf("line_width reads %0d, want %0d", prdata, width_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Queue whole frames of the current width until n_pix pixels are queued.
  // Most frames are clean; with noise on, some lose their frame start (the
  // raster just runs on) and some are cut short, so the next frame start
  // lands mid-row.
  task automatic queue_frames(input int unsigned n_pix, input int unsigned rows_lo,
                              input int unsigned rows_hi, input bit noisy);
    int unsigned  queued;
    int unsigned  frame_len;
    int unsigned  pick;
    bit           mark;
    frame_style_e style;
    logic [7:0]   value;
    queued = 0;
    while (queued < n_pix) begin
      frame_len = $urandom_range(rows_hi, rows_lo) * width_in_use();
      mark = 1'b1;
      if (noisy) begin
        if ($urandom_range(99) < 20) frame_len = $urandom_range(frame_len - 1, 1);
        if ($urandom_range(99) < 10) mark = 1'b0;
      end
      pick  = $urandom_range(5);
      style = (pick > STYLE_BINARY) ? STYLE_NOISE : frame_style_e'(pick);
      for (int i = 0; i < frame_len && queued < n_pix; i++) begin
        case (style)
          STYLE_WHITE:  value = 8'hFF;
          STYLE_BLACK:  value = 8'h00;
          STYLE_BINARY: value = $urandom_range(1) ? 8'hFF : 8'h00;
          default:      value = 8'($urandom_range(255));
        endcase
        push_pixel(value, mark && i == 0);
        queued++;
      end
    end
  endtask

  // One setting of the register and the handshake pressure, then a burst of
  // frames at that setting.
  task automatic run_phase(input logic [31:0] width, input int unsigned gap_pct,
                           input int unsigned stall_pct, input int unsigned n_pix,
                           input int unsigned rows_lo, input int unsigned rows_hi,
                           input bit noisy);
    write_line_width(width);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    queue_frames(n_pix, rows_lo, rows_hi, noisy);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    int unsigned stall;
    logic [31:0] width;
    clear_predictor();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at the reset width (256): extreme pixel values, bit
    // patterns, frame starts back to back and mid-row. All windows here are
    // still partial, so every result must come back zeroed.
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h55, 1'b0);
    push_pixel(8'hAA, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h01, 1'b1);
    push_pixel(8'h80, 1'b1);
    push_pixel(8'hFE, 1'b0);
    push_pixel(8'h7F, 1'b0);
    for (int i = 0; i < 10; i++) push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    wait_drained();

    // Narrowest legal row, widths below the minimum (clamped to 7) and a width
    // of 13, under each handshake pressure.
    run_phase(32'd7,  0,         0,         120, 7, 10, 1'b1);
    run_phase(32'd0,  GAP_HEAVY, 0,         80,  7, 9,  1'b1);
    run_phase(32'd6,  0,         GAP_HEAVY, 80,  7, 9,  1'b1);
    run_phase(32'd13, GAP_BOTH,  GAP_BOTH,  120, 7, 9,  1'b1);

    // One taller frame at the narrowest width runs the row counter well
    // past the window height.
    run_phase(32'd7, GAP_BOTH, GAP_BOTH, 140, 20, 20, 1'b0);

    // Random widths, mostly small, occasionally out of range or near the
    // top. Phases end wherever the count runs out, often mid-row, so the
    // next width takes effect inside a row.
    for (int p = 0; p < 4; p++) begin
      case (p % 4)
        0: begin gap = 0;         stall = 0;         end
        1: begin gap = GAP_HEAVY; stall = 0;         end
        2: begin gap = 0;         stall = GAP_HEAVY; end
        default: begin gap = GAP_BOTH; stall = GAP_BOTH; end
      endcase
      case ($urandom_range(9))
        0:       width = $urandom_range(511);
        1:       width = $urandom_range(256, 200);
        default: width = $urandom_range(12, 7);
      endcase
      if (width > 64) run_phase(width, gap, stall, 50, 1, 1, 1'b1);
      else run_phase(width, gap, stall, 50, 7, 9, 1'b1);
    end

    // Anything arriving now is an extra beat and is flagged by the monitor.
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("box_blur_7x7_stream verification clean");
    end else begin
      $display("box_blur_7x7_stream verification failed");
    end
    $finish;
  end

endmodule

// ===== box_blur_7x7_stream.f =====
hw/rtl/bb7_pkg.sv
hw/rtl/box_blur_7x7_stream.sv
verif/tb_box_blur_7x7_stream.sv
